[design/fmn_pkg.sv]
// ---------------------------------------------------------------------------
// fmn_pkg: shared types and constants of the mantissa normalizer
// Field widths, exponent limits and the record types that travel between
// the datapath and the pipeline registers.
// ---------------------------------------------------------------------------
package fmn_pkg;

  localparam int WORD_W  = 36;
  localparam int MANT_W  = 2 * WORD_W;
  localparam int EXP_W   = 8;
  localparam int SHIFT_W = 7;
  localparam int FLAG_W  = 5;

  localparam logic signed [EXP_W-1:0] EXP_MIN  = 8'sh80;
  localparam logic signed [EXP_W-1:0] EXP_MAX  = 8'sh7f;
  localparam logic signed [EXP_W-1:0] EXP_ZERO = 8'sh00;

  typedef struct packed {
    logic                    overflow_in;
    logic signed [EXP_W-1:0] exponent;
    logic [WORD_W-1:0]       mantissa_low;
    logic [WORD_W-1:0]       mantissa_high;
  } fmn_in_t;

  typedef struct packed {
    logic overflow_out;
    logic exponent_overflow_flag;
    logic underflow_flag;
    logic negative_flag;
    logic zero_flag;
  } fmn_flags_t;

  typedef struct packed {
    fmn_flags_t              flags;
    logic signed [EXP_W-1:0] result_exponent;
    logic [WORD_W-1:0]       result_low;
    logic [WORD_W-1:0]       result_high;
  } fmn_res_t;

endpackage

[design/fmn_norm.sv]
// ---------------------------------------------------------------------------
// fmn_norm: normalization datapath
// Leading-sign count, left barrel shift with exponent limiting, and the
// one-place right shift that corrects a mantissa overflow.
// ---------------------------------------------------------------------------
module fmn_norm (
  input  fmn_pkg::fmn_in_t  item,
  output fmn_pkg::fmn_res_t res
);

  logic [fmn_pkg::MANT_W-1:0]       mant;
  logic [fmn_pkg::MANT_W-2:0]       diff;
  logic [fmn_pkg::SHIFT_W-1:0]      lead;
  logic [fmn_pkg::EXP_W-1:0]        exp_bias;
  logic [fmn_pkg::SHIFT_W-1:0]      shift;
  logic                             mant_zero;
  logic                             unf;
  logic [fmn_pkg::MANT_W-1:0]       mant_out;
  logic signed [fmn_pkg::EXP_W-1:0] exp_out;
  logic                             eovf;

  assign mant = {item.mantissa_high, item.mantissa_low};
  assign diff = mant[fmn_pkg::MANT_W-1:1] ^ mant[fmn_pkg::MANT_W-2:0];
  assign mant_zero = (mant == '0);

  // Count of shifts that brings two unequal bits to the top; all-equal gives the maximum.
  always_comb begin
    lead = fmn_pkg::SHIFT_W'(fmn_pkg::MANT_W - 1);
    for (int i = 0; i < fmn_pkg::MANT_W - 1; i++) begin
      if (diff[i]) begin
        lead = fmn_pkg::SHIFT_W'(fmn_pkg::MANT_W - 2 - i);
      end
    end
  end

  // Exponent offset by 128: the number of decrements left before the minimum.
  assign exp_bias = item.exponent ^ fmn_pkg::EXP_MIN;
  assign unf      = !mant_zero && ({1'b0, lead} > exp_bias);
  assign shift    = unf ? fmn_pkg::SHIFT_W'(exp_bias + 8'd1) : lead;

  always_comb begin
    mant_out = mant << shift;
    exp_out  = fmn_pkg::EXP_W'(item.exponent - $signed({1'b0, lead}));
    eovf     = 1'b0;
    if (item.overflow_in) begin
      mant_out = {~mant[fmn_pkg::MANT_W-1], mant[fmn_pkg::MANT_W-1:1]};
      if (item.exponent == fmn_pkg::EXP_MAX) begin
        exp_out = fmn_pkg::EXP_MIN;
        eovf    = 1'b1;
      end else begin
        exp_out = item.exponent + 8'sd1;
      end
    end else if (mant_zero) begin
      exp_out = fmn_pkg::EXP_MIN;
    end else if (unf) begin
      exp_out = fmn_pkg::EXP_ZERO;
    end
  end

  assign res.result_high     = mant_out[fmn_pkg::MANT_W-1:fmn_pkg::WORD_W];
  assign res.result_low      = mant_out[fmn_pkg::WORD_W-1:0];
  assign res.result_exponent = exp_out;
  assign res.flags.zero_flag              = (mant_out == '0);
  assign res.flags.negative_flag          = mant_out[fmn_pkg::MANT_W-1];
  assign res.flags.underflow_flag         = unf && !item.overflow_in;
  assign res.flags.exponent_overflow_flag = eovf;
  assign res.flags.overflow_out           = 1'b0;

endmodule

[design/float_mantissa_normalizer_core.sv]
// ---------------------------------------------------------------------------
// float_mantissa_normalizer_core: 72-bit mantissa normalizer
// Normalizes a two's complement fraction and adjusts its exponent.
// ---------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_ stream: s_tdata carries the 72-bit fraction as
//   two 36-bit words and the signed exponent, s_tuser the overflow flag of
//   the preceding add. Results leave on the m_ stream: m_tdata carries the
//   normalized words and exponent, m_tuser the five status flags.
//   Every request gives exactly one result, in order.
//   A request is taken into the input register, and the leading-sign count
//   and barrel shift fill the result register from it when that register
//   can advance. Throughput is one request per cycle while the receiver
//   keeps m_tready high; the shift and count finish in a single pass
//   between the two registers.
//   When the receiver holds m_tready low the result register keeps its
//   value, and one more request can still be taken into the input register
//   before s_tready falls.
//   A synchronous reset empties both registers; no result is shown until a
//   new request has been accepted.
// ---------------------------------------------------------------------------
module float_mantissa_normalizer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,   // mantissa_high[35:0], mantissa_low[35:0], exponent[7:0]
  input  logic        s_tuser,   // overflow_in
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,   // result_high[35:0], result_low[35:0], result_exponent[7:0]
  output logic [4:0]  m_tuser    // zero, negative, underflow, exponent_overflow, overflow_out
);

  fmn_pkg::fmn_in_t  in_reg;
  logic              in_valid;
  fmn_pkg::fmn_res_t res_comb;
  fmn_pkg::fmn_res_t res_reg;
  logic              res_valid;
  logic              advance;

  assign advance  = !res_valid || m_tready;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_reg.mantissa_high <= s_tdata[35:0];
      in_reg.mantissa_low  <= s_tdata[71:36];
      in_reg.exponent      <= $signed(s_tdata[79:72]);
      in_reg.overflow_in   <= s_tuser;
    end
  end

  fmn_norm u_norm (
    .item (in_reg),
    .res  (res_comb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      res_reg <= res_comb;
    end
  end

  assign m_tvalid = res_valid;
  assign m_tdata  = {res_reg.result_exponent, res_reg.result_low, res_reg.result_high};
  assign m_tuser  = {res_reg.flags.overflow_out, res_reg.flags.exponent_overflow_flag,
                     res_reg.flags.underflow_flag, res_reg.flags.negative_flag,
                     res_reg.flags.zero_flag};

endmodule

[design/fmn_checker.sv]
// ---------------------------------------------------------------------------
// fmn_checker: port-level checks of the mantissa normalizer
// Watches the result stream for reset, stall hold and consistency between data and flags.
// ---------------------------------------------------------------------------
module fmn_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [79:0] s_tdata,
  input logic        s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [79:0] m_tdata,
  input logic [4:0]  m_tuser
);

  // A reset leaves no result on the output.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result shown right after reset");

  // A stalled result must hold its data and flags.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result changed");

  // The zero and sign flags follow the mantissa delivered with them.
  a_zero_flag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser[0] == (m_tdata[71:0] == 72'd0)))
    else $error("zero flag disagrees with mantissa");

  a_neg_flag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser[1] == m_tdata[35]))
    else $error("negative flag disagrees with sign bit");

  // Underflow forces a zero exponent, never with an exponent wrap, and no overflow remains.
  a_exp_flags: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (!m_tuser[4] && (!m_tuser[2] || (m_tdata[79:72] == 8'd0 && !m_tuser[3]))))
    else $error("exponent flags inconsistent");

endmodule

bind float_mantissa_normalizer_core fmn_checker u_fmn_checker (.*);
